// File: rtl/fuzzy_membership_evaluator_top_macros.svh
// assertion macros used by the checker file
`ifndef FUZZY_MEMBERSHIP_EVALUATOR_TOP_MACROS_SVH
`define FUZZY_MEMBERSHIP_EVALUATOR_TOP_MACROS_SVH

// property checked outside reset
`define FME_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("fme check failed");

// property checked in reset as well
`define FME_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("fme reset check failed");

`endif

// File: rtl/fme_pkg.sv
// shared constants, codes and types of the fuzzy membership evaluator
package fme_pkg;

  localparam int FME_SAMPLE_BITS   = 16;
  localparam int FME_FRACTION_BITS = 16;
  localparam int FME_CFG_IDX_BITS  = 3;
  localparam int FME_KIND_BITS     = 3;

  typedef enum logic [FME_KIND_BITS-1:0] {
    SHAPE_LINEAR,
    SHAPE_TRIANGLE,
    SHAPE_TRAPEZOID,
    SHAPE_S,
    SHAPE_Z,
    SHAPE_PI
  } shape_t;

  typedef enum logic [FME_CFG_IDX_BITS-1:0] {
    CFG_SHAPE_KIND,
    CFG_POINT_A,
    CFG_POINT_B,
    CFG_POINT_C,
    CFG_POINT_D
  } cfg_reg_t;

  // how the quotient turns into the degree
  typedef struct packed {
    logic use_div;  // degree comes from the quotient
    logic one_k;    // constant degree is one (else zero)
    logic square;   // s-curve: 2 r r
    logic invert;   // take one minus the value
  } grade_ctl_t;

endpackage

// File: rtl/fuzzy_membership_evaluator_top.sv
// Fuzzy membership evaluator: grades signed samples against a configured curve.
// Input channel in_valid/in_ready carries one word, in_sample_x (signed fixed point).
// Output channel out_valid/out_ready returns one word per sample, out_degree,
// an unsigned degree with FRACTION_BITS fraction bits (one = 1 << FRACTION_BITS).
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes shape_kind (0)
// and points a..d (1..4); cfg_ready is always high, other indexes are dropped.
// Write configuration only while no sample is in flight.
// The pipeline has one classification stage, one divider stage per quotient bit,
// a squaring stage and the output register. Throughput is one sample per cycle
// while the receiver takes words; the divider pipeline sets depth.
// Reset clears all valid bits and sets the configuration to zero (linear, all
// points zero). When the receiver stalls, each stage holds its word and takes a
// new one only where a later stage is free, so bubbles fill before in_ready drops.
module fuzzy_membership_evaluator_top #(
  parameter int SAMPLE_BITS   = fme_pkg::FME_SAMPLE_BITS,
  parameter int FRACTION_BITS = fme_pkg::FME_FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_x,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [FRACTION_BITS:0]                 out_degree,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fme_pkg::FME_CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [SAMPLE_BITS-1:0]                 cfg_data
);
  import fme_pkg::*;

  logic [FME_KIND_BITS-1:0]      kind_r;
  logic signed [SAMPLE_BITS-1:0] a_r, b_r, c_r, d_r;

  logic                     p_valid, p_ready, d_valid, d_ready;
  logic [SAMPLE_BITS-1:0]   p_num, p_den;
  logic [FRACTION_BITS-1:0] d_quo;
  grade_ctl_t               p_ctl, d_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= '0;
      a_r    <= '0;
      b_r    <= '0;
      c_r    <= '0;
      d_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SHAPE_KIND: kind_r <= cfg_data[FME_KIND_BITS-1:0];
        CFG_POINT_A:    a_r    <= cfg_data;
        CFG_POINT_B:    b_r    <= cfg_data;
        CFG_POINT_C:    c_r    <= cfg_data;
        CFG_POINT_D:    d_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fme_prep #(.SAMPLE_BITS(SAMPLE_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .kind_i  (kind_r),
    .a_i     (a_r),
    .b_i     (b_r),
    .c_i     (c_r),
    .d_i     (d_r),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .x_i     (in_sample_x),
    .valid_o (p_valid),
    .ready_i (p_ready),
    .p_o     (p_num),
    .q_o     (p_den),
    .ctl_o   (p_ctl)
  );

  fme_div #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (p_valid),
    .ready_o (p_ready),
    .p_i     (p_num),
    .q_i     (p_den),
    .ctl_i   (p_ctl),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .quo_o   (d_quo),
    .ctl_o   (d_ctl)
  );

  fme_post #(.FRACTION_BITS(FRACTION_BITS)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (d_valid),
    .ready_o  (d_ready),
    .quo_i    (d_quo),
    .ctl_i    (d_ctl),
    .valid_o  (out_valid),
    .ready_i  (out_ready),
    .degree_o (out_degree)
  );

endmodule

// File: rtl/fme_prep.sv
// classification stage: picks the curve segment, divisor terms and flags
module fme_prep #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [2:0]                    kind_i,
  input  logic signed [SAMPLE_BITS-1:0] a_i,
  input  logic signed [SAMPLE_BITS-1:0] b_i,
  input  logic signed [SAMPLE_BITS-1:0] c_i,
  input  logic signed [SAMPLE_BITS-1:0] d_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [SAMPLE_BITS-1:0]        p_o,
  output logic [SAMPLE_BITS-1:0]        q_o,
  output fme_pkg::grade_ctl_t           ctl_o
);
  import fme_pkg::*;

  function automatic logic [SAMPLE_BITS-1:0] span(input logic signed [SAMPLE_BITS-1:0] hi,
                                                   input logic signed [SAMPLE_BITS-1:0] lo);
    logic [SAMPLE_BITS:0] d;
    d = {hi[SAMPLE_BITS-1], hi} - {lo[SAMPLE_BITS-1], lo};
    return d[SAMPLE_BITS-1:0];
  endfunction

  logic                          v_r;
  logic [SAMPLE_BITS-1:0]        p_r, q_r, p_nxt, q_nxt;
  grade_ctl_t                    ctl_r, ctl_nxt;
  logic signed [SAMPLE_BITS-1:0] lo, hi;
  logic                          zi;
  logic [SAMPLE_BITS+1:0]        twice_x, mid;
  logic                          low_half;

  // s-curve operands: pi switches to the z-curve on (c, d) past c
  always_comb begin
    lo = a_i;
    hi = b_i;
    zi = 1'b0;
    if (shape_t'(kind_i) == SHAPE_Z) begin
      zi = 1'b1;
    end
    if (shape_t'(kind_i) == SHAPE_PI && x_i > c_i) begin
      lo = c_i;
      hi = d_i;
      zi = 1'b1;
    end
    twice_x  = {x_i[SAMPLE_BITS-1], x_i, 1'b0};
    mid      = {{2{lo[SAMPLE_BITS-1]}}, lo} + {{2{hi[SAMPLE_BITS-1]}}, hi};
    low_half = $signed(twice_x) <= $signed(mid);
  end

  always_comb begin
    ctl_nxt = '0;
    p_nxt   = '0;
    q_nxt   = '0;
    case (shape_t'(kind_i))
      SHAPE_LINEAR: begin
        if (a_i < b_i) begin
          if (x_i <= a_i) begin
            ctl_nxt.one_k = 1'b0;
          end else if (x_i >= b_i) begin
            ctl_nxt.one_k = 1'b1;
          end else begin
            ctl_nxt.use_div = 1'b1;
            p_nxt = span(x_i, a_i);
            q_nxt = span(b_i, a_i);
          end
        end else begin
          if (x_i <= b_i) begin
            ctl_nxt.one_k = 1'b1;
          end else if (x_i >= a_i) begin
            ctl_nxt.one_k = 1'b0;
          end else begin
            ctl_nxt.use_div = 1'b1;
            p_nxt = span(a_i, x_i);
            q_nxt = span(a_i, b_i);
          end
        end
      end
      SHAPE_TRIANGLE: begin
        if (x_i <= a_i || x_i >= c_i) begin
          ctl_nxt.one_k = 1'b0;
        end else if (x_i < b_i) begin
          ctl_nxt.use_div = 1'b1;
          p_nxt = span(x_i, a_i);
          q_nxt = span(b_i, a_i);
        end else if (x_i > b_i) begin
          ctl_nxt.use_div = 1'b1;
          p_nxt = span(c_i, x_i);
          q_nxt = span(c_i, b_i);
        end else begin
          ctl_nxt.one_k = 1'b1;
        end
      end
      SHAPE_TRAPEZOID: begin
        if (x_i <= a_i || x_i >= d_i) begin
          ctl_nxt.one_k = 1'b0;
        end else if (x_i >= b_i && x_i <= c_i) begin
          ctl_nxt.one_k = 1'b1;
        end else if (x_i < b_i) begin
          ctl_nxt.use_div = 1'b1;
          p_nxt = span(x_i, a_i);
          q_nxt = span(b_i, a_i);
        end else begin
          ctl_nxt.use_div = 1'b1;
          p_nxt = span(d_i, x_i);
          q_nxt = span(d_i, c_i);
        end
      end
      SHAPE_S, SHAPE_Z, SHAPE_PI: begin
        ctl_nxt.invert = zi;
        if (x_i <= lo) begin
          ctl_nxt.one_k = 1'b0;
        end else if (x_i >= hi) begin
          ctl_nxt.one_k = 1'b1;
        end else begin
          ctl_nxt.use_div = 1'b1;
          ctl_nxt.square  = 1'b1;
          ctl_nxt.invert  = zi ^ ~low_half;
          p_nxt = low_half ? span(x_i, lo) : span(hi, x_i);
          q_nxt = span(hi, lo);
        end
      end
      default: begin
        ctl_nxt = '0;
      end
    endcase
  end

  assign ready_o = !v_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      p_r   <= p_nxt;
      q_r   <= q_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign valid_o = v_r;
  assign p_o     = p_r;
  assign q_o     = q_r;
  assign ctl_o   = ctl_r;

endmodule

// File: rtl/fme_div.sv
// pipelined restoring divider, one quotient bit per stage
module fme_div #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [SAMPLE_BITS-1:0]     p_i,
  input  logic [SAMPLE_BITS-1:0]     q_i,
  input  fme_pkg::grade_ctl_t        ctl_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [FRACTION_BITS-1:0]   quo_o,
  output fme_pkg::grade_ctl_t        ctl_o
);
  import fme_pkg::*;

  logic                     stg_v   [FRACTION_BITS+1];
  logic [SAMPLE_BITS-1:0]   stg_rem [FRACTION_BITS+1];
  logic [SAMPLE_BITS-1:0]   stg_q   [FRACTION_BITS+1];
  logic [FRACTION_BITS-1:0] stg_quo [FRACTION_BITS+1];
  grade_ctl_t               stg_ctl [FRACTION_BITS+1];
  logic                     rdy     [FRACTION_BITS+1];

  assign stg_v[0]   = valid_i;
  assign stg_rem[0] = p_i;
  assign stg_q[0]   = q_i;
  assign stg_quo[0] = '0;
  assign stg_ctl[0] = ctl_i;
  assign rdy[FRACTION_BITS] = ready_i;

  for (genvar s = 1; s <= FRACTION_BITS; s++) begin : g_step
    logic                     v_r;
    logic [SAMPLE_BITS-1:0]   rem_r, q_r, rem_nxt;
    logic [FRACTION_BITS-1:0] quo_r, quo_nxt;
    grade_ctl_t               ctl_r;
    logic [SAMPLE_BITS:0]     t, diff;
    logic                     ge;

    // remainder stays below the divisor, so the doubled value fits one more bit
    always_comb begin
      t       = {stg_rem[s-1], 1'b0};
      diff    = t - {1'b0, stg_q[s-1]};
      ge      = t >= {1'b0, stg_q[s-1]};
      rem_nxt = ge ? diff[SAMPLE_BITS-1:0] : t[SAMPLE_BITS-1:0];
      quo_nxt = {stg_quo[s-1][FRACTION_BITS-2:0], ge};
    end

    assign rdy[s-1] = !v_r || rdy[s];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (rdy[s-1]) begin
        v_r <= stg_v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (stg_v[s-1] && rdy[s-1]) begin
        rem_r <= rem_nxt;
        q_r   <= stg_q[s-1];
        quo_r <= quo_nxt;
        ctl_r <= stg_ctl[s-1];
      end
    end

    assign stg_v[s]   = v_r;
    assign stg_rem[s] = rem_r;
    assign stg_q[s]   = q_r;
    assign stg_quo[s] = quo_r;
    assign stg_ctl[s] = ctl_r;
  end

  assign ready_o = rdy[0];
  assign valid_o = stg_v[FRACTION_BITS];
  assign quo_o   = stg_quo[FRACTION_BITS];
  assign ctl_o   = stg_ctl[FRACTION_BITS];

endmodule

// File: rtl/fme_post.sv
// squaring stage and output register with clamp and inversion
module fme_post #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [FRACTION_BITS-1:0] quo_i,
  input  fme_pkg::grade_ctl_t      ctl_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [FRACTION_BITS:0]   degree_o
);
  import fme_pkg::*;

  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic                       va_r, vb_r, rdy_b;
  logic [2*FRACTION_BITS-1:0] prod_r;
  logic [FRACTION_BITS:0]     val_r, val_nxt;
  logic                       sq_r, inv_r;
  logic [FRACTION_BITS:0]     deg_r, deg_nxt, twice_sq, t;

  assign val_nxt = ctl_i.use_div ? {1'b0, quo_i} : {ctl_i.one_k, {FRACTION_BITS{1'b0}}};

  assign rdy_b   = !vb_r || ready_i;
  assign ready_o = !va_r || rdy_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_o) begin
        va_r <= valid_i;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      prod_r <= quo_i * quo_i;
      val_r  <= val_nxt;
      sq_r   <= ctl_i.square;
      inv_r  <= ctl_i.invert;
    end
  end

  // (2 r r) >> F, clamped to one
  always_comb begin
    twice_sq = prod_r[2*FRACTION_BITS-1:FRACTION_BITS-1];
    t        = sq_r ? ((twice_sq > ONE) ? ONE : twice_sq) : val_r;
    deg_nxt  = inv_r ? ONE - t : t;
  end

  always_ff @(posedge clk) begin
    if (va_r && rdy_b) begin
      deg_r <= deg_nxt;
    end
  end

  assign valid_o  = vb_r;
  assign degree_o = deg_r;

endmodule

// File: rtl/fme_checker.sv
// port-level checks of the fuzzy membership evaluator and their binding
`include "fuzzy_membership_evaluator_top_macros.svh"

module fme_checker #(
  parameter int SAMPLE_BITS   = fme_pkg::FME_SAMPLE_BITS,
  parameter int FRACTION_BITS = fme_pkg::FME_FRACTION_BITS
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic signed [SAMPLE_BITS-1:0]        in_sample_x,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [FRACTION_BITS:0]               out_degree,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [fme_pkg::FME_CFG_IDX_BITS-1:0] cfg_index,
  input logic [SAMPLE_BITS-1:0]               cfg_data
);
  import fme_pkg::*;

  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // a waiting word is not dropped
  `FME_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  // degree never exceeds one
  `FME_ASSERT(a_deg_range, out_valid |-> out_degree <= ONE)
  // nothing leaves the pipeline straight after reset
  `FME_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid)
  // free output register means the front end can take a word
  `FME_ASSERT(a_no_block, !out_valid |-> in_ready)

endmodule

bind fuzzy_membership_evaluator_top fme_checker #(
  .SAMPLE_BITS   (SAMPLE_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_fme_checker (.*);

// File: tb/tb_top.sv
// testbench for the fuzzy membership evaluator: curve prediction and scoreboard
module tb_top;
  import fme_pkg::*;

  localparam int ONE = 1 << 16;
  localparam int LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample_x = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [16:0] out_degree;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [2:0] kind_q;
  logic signed [15:0] pa_q, pb_q, pc_q, pd_q;
  logic [16:0] degree_q[$];
  int errors = 0;
  int samples_sent = 0;
  int degrees_seen = 0;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fuzzy_membership_evaluator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_x(in_sample_x),
    .out_valid(out_valid), .out_ready(out_ready), .out_degree(out_degree),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic longint frac_of(longint p, longint q);
    if (q <= 0 || p < 0) return 0;
    return (p <<< 16) / q;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  function automatic longint ramp(longint x, longint a, longint b);
    longint da, dw;
    if (a < b) begin
      if (x <= a) return 0;
      if (x >= b) return ONE;
    end else begin
      if (x <= b) return ONE;
      if (x >= a) return 0;
    end
    da = (x > a) ? x - a : a - x;
    dw = (b > a) ? b - a : a - b;
    return clamp_one(frac_of(da, dw));
  endfunction

  function automatic longint s_shape(longint x, longint a, longint b);
    longint r;
    if (x <= a) return 0;
    if (x >= b) return ONE;
    if (2 * x <= a + b) begin
      r = frac_of(x - a, b - a);
      return clamp_one((2 * r * r) >>> 16);
    end
    r = frac_of(b - x, b - a);
    return clamp_one(ONE - ((2 * r * r) >>> 16));
  endfunction

  function automatic logic [16:0] grade(logic signed [15:0] xs);
    longint x, a, b, c, d, g;
    x = xs; a = pa_q; b = pb_q; c = pc_q; d = pd_q;
    case (kind_q)
      SHAPE_LINEAR: g = ramp(x, a, b);
      SHAPE_TRIANGLE: begin
        if (x <= a || x >= c) g = 0;
        else if (x < b) g = ramp(x, a, b);
        else if (x > b) g = ramp(x, c, b);
        else g = ONE;
      end
      SHAPE_TRAPEZOID: begin
        if (x <= a || x >= d) g = 0;
        else if (x >= b && x <= c) g = ONE;
        else if (x < b) g = ramp(x, a, b);
        else g = ramp(x, d, c);
      end
      SHAPE_S: g = s_shape(x, a, b);
      SHAPE_Z: g = ONE - s_shape(x, a, b);
      SHAPE_PI: g = (x <= c) ? s_shape(x, a, b) : ONE - s_shape(x, c, d);
      default: g = 0;
    endcase
    return 17'(clamp_one(g));
  endfunction

  // receiver with random stalls, checks each word against the oldest prediction
  initial begin
    int stall;
    logic [16:0] exp_deg;
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) stall = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      degrees_seen++;
      if (degree_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected degree, expected none, actual %0d", $time, out_degree);
      end else begin
        exp_deg = degree_q.pop_front();
        if (out_degree !== exp_deg) begin
          errors++;
          $display("%0t: degree expected %0d actual %0d", $time, exp_deg, out_degree);
        end
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("fuzzy_membership_evaluator_top: mismatch");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SHAPE_KIND: kind_q = val[2:0];
      CFG_POINT_A: pa_q = val;
      CFG_POINT_B: pb_q = val;
      CFG_POINT_C: pc_q = val;
      CFG_POINT_D: pd_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // called at a falling edge once the last word has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (degree_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_curve(logic [2:0] k, logic [15:0] a, logic [15:0] b,
                           logic [15:0] c, logic [15:0] d);
    wait_drained();
    write_reg(CFG_SHAPE_KIND, {13'd0, k});
    write_reg(CFG_POINT_A, a);
    write_reg(CFG_POINT_B, b);
    write_reg(CFG_POINT_C, c);
    write_reg(CFG_POINT_D, d);
  endtask

  // entered and left at a falling edge; valid stays up so words can follow back to back
  task automatic send_sample(logic [15:0] x, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gaps && $urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_x <= x;
    do @(posedge clk); while (!in_ready);
    degree_q = {degree_q, grade(x)};
    samples_sent++;
    @(negedge clk);
  endtask

  // sample biased toward the breakpoints
  function automatic logic [15:0] pick_x();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return pa_q + 16'($urandom_range(0, 4)) - 16'sd2;
      2: return pb_q + 16'($urandom_range(0, 4)) - 16'sd2;
      3: return pc_q + 16'($urandom_range(0, 4)) - 16'sd2;
      4: return pd_q + 16'($urandom_range(0, 4)) - 16'sd2;
      default: return pa_q + 16'($urandom_range(0, 2000)) - 16'sd1000;
    endcase
  endfunction

  task automatic test_reset_curve();
    send_sample(16'h8000, 0);
    send_sample(16'h0000, 0);
    send_sample(16'h7fff, 0);
  endtask

  task automatic test_directed_shapes();
    logic [15:0] xs[8] = '{16'h8000, 16'h7fff, 16'hff00, 16'h0000,
                           16'h0080, 16'h0100, 16'h0180, 16'h0300};
    for (int k = 0; k < 8; k++) begin
      // ordered breakpoints, for every kind code
      set_curve(3'(k), 16'hff00, 16'h0100, 16'h0200, 16'h0300);
      foreach (xs[i]) send_sample(xs[i], 1);
    end
    set_curve(SHAPE_LINEAR, 16'h0100, 16'hff00, 16'h0, 16'h0);  // falling ramp
    send_sample(16'h0000, 0);
    send_sample(16'h0100, 0);
    set_curve(SHAPE_TRAPEZOID, 16'h0100, 16'h0100, 16'h0100, 16'h0100);
    send_sample(16'h0100, 0);
    set_curve(SHAPE_S, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);  // widest span
    send_sample(16'h0000, 0);
    send_sample(16'h8001, 0);
    send_sample(16'h7ffe, 0);
    // out-of-list index must be dropped
    wait_drained();
    write_reg(cfg_reg_t'(3'd7), 16'hffff);
    send_sample(16'h1234, 0);
  endtask

  task automatic test_random_curves();
    logic [15:0] p[4];
    for (int s = 0; s < 40; s++) begin
      foreach (p[i]) p[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 4000)) - 16'd2000;
      if ($urandom_range(0, 3) != 0) p.sort() with (signed'(item));
      set_curve(3'($urandom_range(0, 7)), p[0], p[1], p[2], p[3]);
      for (int i = 0; i < 50; i++) send_sample(pick_x(), s % 4 != 0);
    end
  endtask

  initial begin
    kind_q = SHAPE_LINEAR;
    pa_q = '0; pb_q = '0; pc_q = '0; pd_q = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_curve();
    test_directed_shapes();
    test_random_curves();
    wait_drained();
    $display("ran %0d samples over all curve kinds, %0d degrees checked", samples_sent,
             degrees_seen);
    if (errors == 0) $display("fuzzy_membership_evaluator_top: match");
    else $display("fuzzy_membership_evaluator_top: mismatch");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/fme_pkg.sv
rtl/fme_prep.sv
rtl/fme_div.sv
rtl/fme_post.sv
rtl/fuzzy_membership_evaluator_top.sv
rtl/fme_checker.sv
tb/tb_top.sv
